// File: rtl/core/ecmp_pkg.sv
// ----------------------------------------------------------------------------
// ECMP flow hash package
// Types, constants and the CRC-32 byte update shared by the path select block.
// ----------------------------------------------------------------------------
package ecmp_pkg;

  // Frame layout and key geometry.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [5:0]  TYPE_POS       = 6'd12;
  localparam logic [5:0]  PROTO_POS      = 6'd23;
  localparam logic [5:0]  ADDR_POS       = 6'd26;
  localparam logic [5:0]  PORT_POS       = 6'd34;
  localparam logic [5:0]  POS_SAT        = 6'd38;
  localparam int          ADDR_BYTES     = 8;
  localparam int          PORT_BYTES     = 4;
  localparam int          STORED_BYTES   = ADDR_BYTES + PORT_BYTES;
  localparam int          KEY_BYTES      = 14;
  localparam int          KEY_BITS       = KEY_BYTES * 8;

  // Path count handling.
  localparam int          PATH_W         = 11;
  localparam int          PATH_FIELD_MAX = 2047;
  localparam int          MAX_PATHS_DEF  = 1024;

  // CRC-32, reflected form.
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;

  // Job queue between the parser and the hash engine.
  localparam int          JOBQ_DEPTH     = 2;
  localparam int          JOBQ_AW        = $clog2(JOBQ_DEPTH);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_IPV4  = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CRC,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic              last_byte;
    logic [PATH_W-1:0] path_count;
  } frame_item_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  path_index;
    logic [31:0] flow_hash;
  } result_item_t;

  // One parsed frame waiting for the hash engine.
  typedef struct packed {
    status_t             status;
    logic [PATH_W-1:0]   paths;
    logic [KEY_BITS-1:0] key;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/ecmp_front.sv
// ----------------------------------------------------------------------------
// ECMP frame parser
// Takes frame bytes, collects the flow key and hands one job per frame on.
// ----------------------------------------------------------------------------
module ecmp_front #(
  parameter int MAX_PATHS = ecmp_pkg::MAX_PATHS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ecmp_pkg::frame_item_t frame,
  input  logic                  accept,
  output ecmp_pkg::job_t        job,
  output logic                  job_push
);

  localparam int PathCap = (MAX_PATHS < ecmp_pkg::PATH_FIELD_MAX) ?
                           MAX_PATHS : ecmp_pkg::PATH_FIELD_MAX;

  logic [5:0]                  pos;
  logic [15:0]                 ether_type;
  logic [7:0]                  proto;
  logic [ecmp_pkg::PATH_W-1:0] paths;
  logic [7:0]                  key_store [ecmp_pkg::STORED_BYTES];

  logic [15:0]                 ether_cur;
  logic [7:0]                  proto_cur;
  logic [ecmp_pkg::PATH_W-1:0] paths_cur;
  logic [ecmp_pkg::PATH_W-1:0] pc_clamped;
  logic                        ports;
  logic [6:0]                  need;
  logic [6:0]                  pos_inc;
  logic                        key_wr;
  logic [3:0]                  key_idx;
  logic [7:0]                  key_cur [ecmp_pkg::STORED_BYTES];

  always_comb begin
    priority if (frame.path_count == '0) begin
      pc_clamped = ecmp_pkg::PATH_W'(1);
    end else if (32'(frame.path_count) > PathCap) begin
      pc_clamped = ecmp_pkg::PATH_W'(PathCap);
    end else begin
      pc_clamped = frame.path_count;
    end
  end

  always_comb begin
    paths_cur = (pos == '0) ? pc_clamped : paths;
    ether_cur = ether_type;
    if (pos == ecmp_pkg::TYPE_POS) begin
      ether_cur = {frame.frame_byte, 8'h00};
    end else if (pos == ecmp_pkg::TYPE_POS + 6'd1) begin
      ether_cur = {ether_type[15:8], frame.frame_byte};
    end
    proto_cur = (pos == ecmp_pkg::PROTO_POS) ? frame.frame_byte : proto;
    ports     = (proto_cur == ecmp_pkg::PROTO_UDP) || (proto_cur == ecmp_pkg::PROTO_TCP);
    need      = {1'b0, ports ? ecmp_pkg::POS_SAT : ecmp_pkg::PORT_POS};
    pos_inc   = {1'b0, pos} + 7'd1;
  end

  // Address bytes land in slots 0..7, port bytes in slots 8..11.
  always_comb begin
    key_wr  = 1'b0;
    key_idx = '0;
    if (pos >= ecmp_pkg::ADDR_POS && pos < ecmp_pkg::POS_SAT) begin
      key_wr  = 1'b1;
      key_idx = 4'(pos - ecmp_pkg::ADDR_POS);
    end
    for (int i = 0; i < ecmp_pkg::STORED_BYTES; i++) begin
      key_cur[i] = (key_wr && key_idx == 4'(i)) ? frame.frame_byte : key_store[i];
    end
  end

  always_comb begin
    job.paths = paths_cur;
    for (int i = 0; i < ecmp_pkg::ADDR_BYTES; i++) begin
      job.key[i*8 +: 8] = key_cur[i];
    end
    job.key[ecmp_pkg::ADDR_BYTES*8 +: 8] = proto_cur;
    for (int i = 0; i < ecmp_pkg::PORT_BYTES; i++) begin
      job.key[(ecmp_pkg::ADDR_BYTES+1+i)*8 +: 8] =
        ports ? key_cur[ecmp_pkg::ADDR_BYTES+i] : 8'h00;
    end
    job.key[(ecmp_pkg::KEY_BYTES-1)*8 +: 8] = 8'h00;

    priority if (pos < ecmp_pkg::TYPE_POS + 6'd1) begin
      job.status = ecmp_pkg::STATUS_TRUNCATED;
    end else if (ether_cur != ecmp_pkg::ETHERTYPE_IPV4) begin
      job.status = ecmp_pkg::STATUS_NOT_IPV4;
    end else if (pos_inc < need) begin
      job.status = ecmp_pkg::STATUS_TRUNCATED;
    end else begin
      job.status = ecmp_pkg::STATUS_OK;
    end

    job_push = accept && frame.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ether_type <= '0;
      proto      <= '0;
      paths      <= ecmp_pkg::PATH_W'(1);
    end else if (accept) begin
      paths <= paths_cur;
      if (frame.last_byte) begin
        pos        <= '0;
        ether_type <= '0;
        proto      <= '0;
      end else begin
        ether_type <= ether_cur;
        proto      <= proto_cur;
        if (pos < ecmp_pkg::POS_SAT) begin
          pos <= pos + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && key_wr) begin
      key_store[key_idx] <= frame.frame_byte;
    end
  end

  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && frame.last_byte) |=> (pos == '0 && ether_type == '0 && proto == '0))
    else $error("byte position not cleared after the last byte of a frame");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= ecmp_pkg::POS_SAT)
    else $error("byte position passed its saturation point");

endmodule

// File: rtl/core/ecmp_jobq.sv
// ----------------------------------------------------------------------------
// ECMP job queue
// Short first-in first-out store of parsed frames between parser and engine.
// ----------------------------------------------------------------------------
module ecmp_jobq (
  input  logic           clk,
  input  logic           rst,
  input  ecmp_pkg::job_t wr_job,
  input  logic           wr,
  output logic           q_full,
  output ecmp_pkg::job_t rd_job,
  input  logic           rd,
  output logic           q_empty
);

  ecmp_pkg::job_t                mem [ecmp_pkg::JOBQ_DEPTH];
  logic [ecmp_pkg::JOBQ_AW-1:0]  wr_ptr;
  logic [ecmp_pkg::JOBQ_AW-1:0]  rd_ptr;
  logic [ecmp_pkg::JOBQ_AW:0]    count;

  assign q_full  = (count == (ecmp_pkg::JOBQ_AW+1)'(ecmp_pkg::JOBQ_DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !wr)
    else $error("job written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !rd)
    else $error("job read from an empty queue");

endmodule

// File: rtl/core/ecmp_back.sv
// ----------------------------------------------------------------------------
// ECMP hash engine
// Runs CRC-32 over a good frame's flow key a byte per cycle, then reduces it modulo the
// path count a bit per cycle, and holds the result until it is taken; other frames are held at once.
// ----------------------------------------------------------------------------
module ecmp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ecmp_pkg::job_t         job,
  input  logic                   q_empty,
  output logic                   job_pop,
  output ecmp_pkg::result_item_t result,
  output logic                   empty,
  input  logic                   pop
);

  ecmp_pkg::back_state_t         state;
  ecmp_pkg::back_state_t         state_next;
  logic [4:0]                    cnt;
  logic [31:0]                   acc;
  logic [ecmp_pkg::KEY_BITS-1:0] key;
  logic [31:0]                   dividend;
  logic [ecmp_pkg::PATH_W-1:0]   paths;
  logic [ecmp_pkg::PATH_W-1:0]   rem;

  logic [31:0]                   acc_next;
  logic [ecmp_pkg::PATH_W:0]     rem_shift;
  logic [ecmp_pkg::PATH_W-1:0]   rem_next;
  logic                          crc_last;
  logic                          div_last;

  // Datapath steps: one key byte into the CRC, one dividend bit into the
  // restoring remainder.
  always_comb begin
    acc_next  = ecmp_pkg::crc_byte(acc, key[7:0]);
    rem_shift = {rem, dividend[31]};
    if (rem_shift >= {1'b0, paths}) begin
      rem_next = ecmp_pkg::PATH_W'(rem_shift - {1'b0, paths});
    end else begin
      rem_next = rem_shift[ecmp_pkg::PATH_W-1:0];
    end
    crc_last = (cnt == 5'(ecmp_pkg::KEY_BYTES - 1));
    div_last = (cnt == 5'd31);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ecmp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = (job.status == ecmp_pkg::STATUS_OK) ? ecmp_pkg::BK_CRC :
                                                             ecmp_pkg::BK_HOLD;
        end
      end
      ecmp_pkg::BK_CRC: begin
        if (crc_last) begin
          state_next = ecmp_pkg::BK_DIV;
        end
      end
      ecmp_pkg::BK_DIV: begin
        if (div_last) begin
          state_next = ecmp_pkg::BK_HOLD;
        end
      end
      ecmp_pkg::BK_HOLD: begin
        if (pop) begin
          state_next = ecmp_pkg::BK_IDLE;
        end
      end
      default: state_next = ecmp_pkg::BK_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    job_pop = (state == ecmp_pkg::BK_IDLE) && !q_empty;
    empty   = (state != ecmp_pkg::BK_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecmp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ecmp_pkg::BK_IDLE: begin
        cnt      <= '0;
        acc      <= ecmp_pkg::CRC_INIT;
        key      <= job.key;
        paths    <= job.paths;
        rem      <= '0;
        result   <= '{status: job.status, path_index: '0, flow_hash: '0};
      end
      ecmp_pkg::BK_CRC: begin
        acc <= acc_next;
        key <= key >> 8;
        cnt <= crc_last ? 5'd0 : cnt + 5'd1;
        if (crc_last) begin
          dividend         <= ~acc_next;
          result.flow_hash <= ~acc_next;
        end
      end
      ecmp_pkg::BK_DIV: begin
        rem      <= rem_next;
        dividend <= dividend << 1;
        cnt      <= cnt + 5'd1;
        if (div_last) begin
          result.path_index <= rem_next[9:0];
        end
      end
      ecmp_pkg::BK_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ecmp_pkg::BK_DIV) |-> (rem < paths))
    else $error("partial remainder not below the path count");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ecmp_pkg::BK_HOLD && result.status != ecmp_pkg::STATUS_OK) |->
    (result.flow_hash == '0 && result.path_index == '0))
    else $error("failed frame carries a hash or an index");

  a_hold_release: assert property (@(posedge clk) disable iff (rst)
    (state == ecmp_pkg::BK_HOLD && pop) |=> (state == ecmp_pkg::BK_IDLE))
    else $error("engine did not release after its result was taken");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ecmp_pkg::BK_HOLD && !pop) |=> $stable(result))
    else $error("waiting result changed before it was taken");

endmodule

// File: rtl/core/ecmp_flow_hash_path_select.sv
// Order: a well-formed IPv4 frame's job is claimed from the queue, then the byte-wise CRC runs over
// the key and the bit-wise remainder over the hash; any other frame's job goes straight to its result.
// Throughput: one byte per cycle while the two-deep job queue has room; the hash engine works
// on one frame at a time and takes no new job until its result has been popped.
// Reset: synchronous and active high; it clears the parser, the queue and the engine, and
// sets the latched path count to one. No memory needs a clearing pass.
// ----------------------------------------------------------------------------
// ECMP flow hash and path select
// Parses a byte-serial Ethernet frame, hashes its five-tuple flow key with
// CRC-32 and picks an equal-cost path index as the hash modulo the path count.
// ----------------------------------------------------------------------------
module ecmp_flow_hash_path_select #(
  parameter int MAX_PATHS = ecmp_pkg::MAX_PATHS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Frame bytes in, one item per byte.
  input  ecmp_pkg::frame_item_t  frame,
  input  logic                   push,
  output logic                   full,
  // One result item per frame, held until it is popped.
  output ecmp_pkg::result_item_t result,
  output logic                   empty,
  input  logic                   pop
);

  // The parser takes a byte whenever the job queue has room, so a frame's
  // last byte always finds a free slot for its job.
  ecmp_pkg::job_t parsed_job;
  ecmp_pkg::job_t queued_job;
  logic           job_push;
  logic           job_pop;
  logic           q_full;
  logic           q_empty;
  logic           accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Front end: byte position, EtherType and protocol tracking, and the key
  // bytes; it classifies each frame as good, not IPv4 or truncated.
  ecmp_front #(
    .MAX_PATHS (MAX_PATHS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .accept   (accept),
    .job      (parsed_job),
    .job_push (job_push)
  );

  // Job queue: lets the parser keep taking bytes while the engine works on
  // an earlier frame or waits for its result to be taken.
  ecmp_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_job  (parsed_job),
    .wr      (job_push),
    .q_full  (q_full),
    .rd_job  (queued_job),
    .rd      (job_pop),
    .q_empty (q_empty)
  );

  // Back end: the CRC and the remainder unit, with the result register that
  // holds the item until it is popped.
  ecmp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (queued_job),
    .q_empty (q_empty),
    .job_pop (job_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
